### design/cdp_alu_pkg.sv
// Shared types and constants for the conditional data-processing ALU.
// Holds opcode, condition and shift kind encodings plus stream widths.
// No dependencies.
package cdp_alu_pkg;

    localparam int unsigned WordWidth    = 32;
    localparam int unsigned RegIdxWidth  = 4;
    localparam int unsigned FlagWidth    = 4;
    localparam int unsigned InDataWidth  = 4 * WordWidth;
    // 44 bits of result fields padded to whole bytes
    localparam int unsigned OutDataWidth = 48;

    // positions of the flags in the NZCV nibble
    localparam int unsigned FlagN = 3;
    localparam int unsigned FlagZ = 2;
    localparam int unsigned FlagC = 1;
    localparam int unsigned FlagV = 0;

    // program counter register index
    localparam logic [RegIdxWidth-1:0] PcIndex = 4'hF;

    typedef enum logic [3:0] {
        OP_AND = 4'h0,
        OP_EOR = 4'h1,
        OP_SUB = 4'h2,
        OP_RSB = 4'h3,
        OP_ADD = 4'h4,
        OP_ADC = 4'h5,
        OP_SBC = 4'h6,
        OP_RSC = 4'h7,
        OP_TST = 4'h8,
        OP_TEQ = 4'h9,
        OP_CMP = 4'hA,
        OP_CMN = 4'hB,
        OP_ORR = 4'hC,
        OP_MOV = 4'hD,
        OP_BIC = 4'hE,
        OP_MVN = 4'hF
    } alu_op_t;

    typedef enum logic [3:0] {
        COND_EQ = 4'h0,
        COND_NE = 4'h1,
        COND_CS = 4'h2,
        COND_CC = 4'h3,
        COND_MI = 4'h4,
        COND_PL = 4'h5,
        COND_VS = 4'h6,
        COND_VC = 4'h7,
        COND_HI = 4'h8,
        COND_LS = 4'h9,
        COND_GE = 4'hA,
        COND_LT = 4'hB,
        COND_GT = 4'hC,
        COND_LE = 4'hD,
        COND_AL = 4'hE,
        COND_NV = 4'hF
    } cond_t;

    typedef enum logic [1:0] {
        SHIFT_LSL = 2'd0,
        SHIFT_LSR = 2'd1,
        SHIFT_ASR = 2'd2,
        SHIFT_ROR = 2'd3
    } shift_kind_t;

endpackage

### design/cond_data_processing_alu.sv
// Top level of the conditional data-processing ALU with barrel shifter.
// Uses cdp_alu_pkg for encodings and widths.
// Input register, single-pass ALU logic, result register and the NZCV flags.

// Executes one data-processing instruction per transfer: the condition is
// tested against the held NZCV flags, operand two comes from the rotated
// immediate or from Rm through the barrel shifter, and the flags are updated
// when S is set or for the test opcodes. One item is accepted every clock
// cycle while the downstream side keeps m_axis_tready high. An input transfer
// loads the input register; the item moves into the result register once
// that is free or being emptied. The flags register is written as an item
// leaves the input register, so the next item already sees the updated
// flags. The result register lets a new item enter while a finished result
// still waits for the downstream side; with both registers full and
// m_axis_tready low, s_axis_tready drops.
module cond_data_processing_alu
    import cdp_alu_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // fields from bit 0: instruction[31:0], first_value[63:32],
    // second_value[95:64], shift_value[127:96]
    input  logic [InDataWidth-1:0]  s_axis_tdata,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // fields from bit 0: result_value[31:0], dest_index[35:32],
    // write_enable[36], cond_passed[37], flags_out[41:38], flush_pipe[42],
    // unsupported[43], zero fill[47:44]
    output logic [OutDataWidth-1:0] m_axis_tdata,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready
);

    // handshake and control
    logic                   in_valid_reg;
    logic                   in_valid_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   in_xfer;
    logic                   advance;
    logic [FlagWidth-1:0]   flags_reg;
    logic [FlagWidth-1:0]   flags_next;

    // input register
    logic [WordWidth-1:0]   ins_reg;
    logic [WordWidth-1:0]   rn_val_reg;
    logic [WordWidth-1:0]   rm_val_reg;
    logic [WordWidth-1:0]   rs_val_reg;

    // result register
    logic [WordWidth-1:0]   result_value_reg;
    logic [RegIdxWidth-1:0] dest_index_reg;
    logic                   write_enable_reg;
    logic                   cond_passed_reg;
    logic [FlagWidth-1:0]   flags_out_reg;
    logic                   flush_pipe_reg;
    logic                   unsupported_reg;

    // decode
    alu_op_t                opcode;
    cond_t                  cond;
    shift_kind_t            sh_kind;
    logic                   s_bit;
    logic                   is_test;
    logic                   unsup;
    logic                   passed;
    logic                   shift_by_reg;
    logic [RegIdxWidth-1:0] rd;
    logic                   f_n;
    logic                   f_z;
    logic                   f_c;
    logic                   f_v;

    // operands
    logic [WordWidth-1:0]   op1;
    logic [WordWidth-1:0]   sh_x;
    logic [7:0]             sh_amt;
    logic [WordWidth-1:0]   op2;
    logic                   sh_carry;
    logic [WordWidth-1:0]   sh_out;
    logic                   sh_cout;
    logic [WordWidth:0]     lsl_w;
    logic [WordWidth:0]     lsr_w;
    logic [WordWidth:0]     asr_w;
    logic [2*WordWidth-1:0] ror_w;
    logic [2*WordWidth-1:0] imm_w;
    logic [4:0]             imm_rot;
    logic                   sh_zero;
    logic                   sh_big;
    logic                   sh_32;

    // alu
    logic [WordWidth-1:0]   add_a;
    logic [WordWidth-1:0]   add_b;
    logic                   add_c;
    logic                   is_arith;
    logic [WordWidth:0]     sum;
    logic [WordWidth-1:0]   logic_res;
    logic [WordWidth-1:0]   alu_res;
    logic                   alu_c;
    logic                   alu_v;
    logic                   upd_flags;
    logic                   we;

    // stream handshake
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_xfer)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // field decode; a register shift exists only for register operand two
    assign opcode       = alu_op_t'(ins_reg[24:21]);
    assign cond         = cond_t'(ins_reg[31:28]);
    assign sh_kind      = shift_kind_t'(ins_reg[6:5]);
    assign s_bit        = ins_reg[20];
    assign rd           = ins_reg[15:12];
    assign shift_by_reg = !ins_reg[25] && ins_reg[4];
    assign is_test      = (opcode == OP_TST) || (opcode == OP_TEQ) ||
                          (opcode == OP_CMP) || (opcode == OP_CMN);
    assign unsup        = is_test && !s_bit;
    assign f_n          = flags_reg[FlagN];
    assign f_z          = flags_reg[FlagZ];
    assign f_c          = flags_reg[FlagC];
    assign f_v          = flags_reg[FlagV];

    // condition check
    always_comb
    begin
        unique case (cond)
            COND_EQ: passed = f_z;
            COND_NE: passed = !f_z;
            COND_CS: passed = f_c;
            COND_CC: passed = !f_c;
            COND_MI: passed = f_n;
            COND_PL: passed = !f_n;
            COND_VS: passed = f_v;
            COND_VC: passed = !f_v;
            COND_HI: passed = f_c && !f_z;
            COND_LS: passed = !f_c || f_z;
            COND_GE: passed = (f_n == f_v);
            COND_LT: passed = (f_n != f_v);
            COND_GT: passed = !f_z && (f_n == f_v);
            COND_LE: passed = f_z || (f_n != f_v);
            COND_AL: passed = 1'b1;
            COND_NV: passed = 1'b0;
        endcase
    end

    // operand fetch; the pc reads one word further ahead on register shifts
    always_comb
    begin
        op1  = rn_val_reg;
        sh_x = rm_val_reg;
        if (shift_by_reg && (ins_reg[19:16] == PcIndex))
        begin
            op1 = rn_val_reg + WordWidth'(4);
        end
        if (shift_by_reg && (ins_reg[3:0] == PcIndex))
        begin
            sh_x = rm_val_reg + WordWidth'(4);
        end
    end

    // shift amount: low byte of rs or the 5-bit immediate
    assign sh_amt  = shift_by_reg ? rs_val_reg[7:0] : {3'b000, ins_reg[11:7]};
    assign sh_zero = (sh_amt == 8'd0);
    assign sh_big  = |sh_amt[7:5];
    assign sh_32   = (sh_amt == 8'd32);

    assign lsl_w = {1'b0, sh_x} << sh_amt[4:0];
    assign lsr_w = {sh_x, 1'b0} >> sh_amt[4:0];
    assign asr_w = $unsigned($signed({sh_x, 1'b0}) >>> sh_amt[4:0]);
    assign ror_w = {sh_x, sh_x} >> sh_amt[4:0];

    // barrel shifter with the immediate zero-amount encodings
    always_comb
    begin
        sh_out  = sh_x;
        sh_cout = f_c;
        unique case (sh_kind)
            SHIFT_LSL:
            begin
                priority if (sh_zero)
                begin
                    sh_out  = sh_x;
                    sh_cout = f_c;
                end
                else if (!sh_big)
                begin
                    sh_out  = lsl_w[WordWidth-1:0];
                    sh_cout = lsl_w[WordWidth];
                end
                else
                begin
                    sh_out  = '0;
                    sh_cout = sh_32 && sh_x[0];
                end
            end
            SHIFT_LSR:
            begin
                priority if (sh_zero && !shift_by_reg)
                begin
                    sh_out  = '0;
                    sh_cout = sh_x[WordWidth-1];
                end
                else if (sh_zero)
                begin
                    sh_out  = sh_x;
                    sh_cout = f_c;
                end
                else if (!sh_big)
                begin
                    sh_out  = lsr_w[WordWidth:1];
                    sh_cout = lsr_w[0];
                end
                else
                begin
                    sh_out  = '0;
                    sh_cout = sh_32 && sh_x[WordWidth-1];
                end
            end
            SHIFT_ASR:
            begin
                priority if (sh_zero && shift_by_reg)
                begin
                    sh_out  = sh_x;
                    sh_cout = f_c;
                end
                else if (sh_zero || sh_big)
                begin
                    sh_out  = {WordWidth{sh_x[WordWidth-1]}};
                    sh_cout = sh_x[WordWidth-1];
                end
                else
                begin
                    sh_out  = asr_w[WordWidth:1];
                    sh_cout = asr_w[0];
                end
            end
            SHIFT_ROR:
            begin
                priority if (sh_zero && !shift_by_reg)
                begin
                    // rotate right extended through carry
                    sh_out  = {f_c, sh_x[WordWidth-1:1]};
                    sh_cout = sh_x[0];
                end
                else if (sh_zero)
                begin
                    sh_out  = sh_x;
                    sh_cout = f_c;
                end
                else
                begin
                    sh_out  = ror_w[WordWidth-1:0];
                    sh_cout = ror_w[WordWidth-1];
                end
            end
        endcase
    end

    // rotated immediate
    assign imm_rot = {ins_reg[11:8], 1'b0};
    assign imm_w   = {24'd0, ins_reg[7:0], 24'd0, ins_reg[7:0]} >> imm_rot;

    always_comb
    begin
        if (ins_reg[25])
        begin
            op2      = imm_w[WordWidth-1:0];
            sh_carry = (imm_rot == 5'd0) ? f_c : imm_w[WordWidth-1];
        end
        else
        begin
            op2      = sh_out;
            sh_carry = sh_cout;
        end
    end

    // adder operand selection and logical results
    always_comb
    begin
        add_a     = op1;
        add_b     = op2;
        add_c     = 1'b0;
        is_arith  = 1'b0;
        logic_res = '0;
        unique case (opcode)
            OP_AND, OP_TST: logic_res = op1 & op2;
            OP_EOR, OP_TEQ: logic_res = op1 ^ op2;
            OP_SUB, OP_CMP:
            begin
                add_b    = ~op2;
                add_c    = 1'b1;
                is_arith = 1'b1;
            end
            OP_RSB:
            begin
                add_a    = op2;
                add_b    = ~op1;
                add_c    = 1'b1;
                is_arith = 1'b1;
            end
            OP_ADD, OP_CMN: is_arith = 1'b1;
            OP_ADC:
            begin
                add_c    = f_c;
                is_arith = 1'b1;
            end
            OP_SBC:
            begin
                add_b    = ~op2;
                add_c    = f_c;
                is_arith = 1'b1;
            end
            OP_RSC:
            begin
                add_a    = op2;
                add_b    = ~op1;
                add_c    = f_c;
                is_arith = 1'b1;
            end
            OP_ORR: logic_res = op1 | op2;
            OP_MOV: logic_res = op2;
            OP_BIC: logic_res = op1 & ~op2;
            OP_MVN: logic_res = ~op2;
        endcase
    end

    // adder, result and flag selection
    assign sum     = {1'b0, add_a} + {1'b0, add_b} + {{WordWidth{1'b0}}, add_c};
    assign alu_res = is_arith ? sum[WordWidth-1:0] : logic_res;
    assign alu_c   = is_arith ? sum[WordWidth] : sh_carry;
    assign alu_v   = is_arith ? ((add_a[WordWidth-1] ^ alu_res[WordWidth-1]) &
                                 (add_b[WordWidth-1] ^ alu_res[WordWidth-1]))
                              : f_v;

    assign upd_flags = passed && !unsup && (is_test || (s_bit && (rd != PcIndex)));
    assign we        = passed && !unsup && !is_test;

    always_comb
    begin
        flags_next = flags_reg;
        if (upd_flags)
        begin
            flags_next[FlagN] = alu_res[WordWidth-1];
            flags_next[FlagZ] = (alu_res == '0);
            flags_next[FlagC] = alu_c;
            flags_next[FlagV] = alu_v;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                flags_reg <= flags_next;
            end
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            ins_reg    <= s_axis_tdata[WordWidth-1:0];
            rn_val_reg <= s_axis_tdata[2*WordWidth-1:WordWidth];
            rm_val_reg <= s_axis_tdata[3*WordWidth-1:2*WordWidth];
            rs_val_reg <= s_axis_tdata[4*WordWidth-1:3*WordWidth];
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_value_reg <= we ? alu_res : '0;
            dest_index_reg   <= rd;
            write_enable_reg <= we;
            cond_passed_reg  <= passed;
            flags_out_reg    <= flags_next;
            flush_pipe_reg   <= we && (rd == PcIndex);
            unsupported_reg  <= unsup;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, unsupported_reg, flush_pipe_reg, flags_out_reg,
                            cond_passed_reg, write_enable_reg, dest_index_reg,
                            result_value_reg};

    // flags move only when an item leaves the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(flags_reg))
        else $error("flags changed without an item completing");

    // a reported result carries the flags now held
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (flags_out_reg == flags_reg))
        else $error("reported flags differ from held flags");

    // writes only happen for executed, supported instructions
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && write_enable_reg) |-> (cond_passed_reg && !unsupported_reg))
        else $error("write enabled on failed or unsupported instruction");

    // a flush needs a write to the pc
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && flush_pipe_reg) |->
            (write_enable_reg && (dest_index_reg == PcIndex)))
        else $error("flush without a pc write");

endmodule

### tb/sv/cond_data_processing_alu_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for cond_data_processing_alu: streams instructions, predicts
// condition, shifter, ALU and NZCV behavior in place and compares every result transfer.
// Depends on cdp_alu_pkg and the cond_data_processing_alu design.
module cond_data_processing_alu_tb;
    import cdp_alu_pkg::*;

    localparam int unsigned ClkPeriod       = 12;
    localparam int unsigned ResetCycles     = 10;
    localparam int unsigned CycleLimit      = 200000;
    localparam int unsigned LongStallCycles = 300;
    localparam int unsigned DrainCycles     = 8;
    localparam int unsigned MaxReported     = 10;
    localparam int unsigned PhaseItems      = 225;
    localparam int unsigned PressureItems   = 40;

    // one expected result, fields as the block reports them
    typedef struct packed {
        logic [31:0] result_value;
        logic [3:0]  dest_index;
        logic        write_enable;
        logic        cond_passed;
        logic [3:0]  flags_out;
        logic        flush_pipe;
        logic        unsupported;
    } alu_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic [InDataWidth-1:0]  s_tdata = '0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [OutDataWidth-1:0] m_tdata;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;

    // predictor state and result store
    logic [3:0]  model_flags = '0;
    alu_result_t expected_results[$];

    // idle controls for the sender and the receiver
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    logic        long_stall_req = 1'b0;
    int unsigned stall_left = 0;

    int unsigned items_sent = 0;
    int unsigned results_checked = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    always #(ClkPeriod / 2) clk = ~clk;

    cond_data_processing_alu DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_tdata),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready)
    );

    // condition code test against NZCV
    function automatic logic cond_holds(input logic [3:0] code, input logic [3:0] f);
        logic n, z, c, v;
        n = f[FlagN];
        z = f[FlagZ];
        c = f[FlagC];
        v = f[FlagV];
        case (cond_t'(code))
            COND_EQ: return z;
            COND_NE: return !z;
            COND_CS: return c;
            COND_CC: return !c;
            COND_MI: return n;
            COND_PL: return !n;
            COND_VS: return v;
            COND_VC: return !v;
            COND_HI: return c && !z;
            COND_LS: return !c || z;
            COND_GE: return n == v;
            COND_LT: return n != v;
            COND_GT: return !z && (n == v);
            COND_LE: return z || (n != v);
            COND_AL: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // barrel shifter; imm_amt marks an amount taken from the instruction word
    function automatic logic [31:0] barrel_shift(input logic [31:0] x,
            input shift_kind_t kind, input logic [7:0] amt, input logic imm_amt,
            input logic cin, output logic cout);
        int unsigned n;
        logic [4:0]  rot;
        n = amt;
        rot = amt[4:0];
        // a zero amount means LSR/ASR #32 and RRX when encoded in the word
        if (n == 0) begin
            cout = cin;
            if (!imm_amt)
                return x;
            case (kind)
                SHIFT_LSL: return x;
                SHIFT_LSR:
                begin
                    cout = x[31];
                    return '0;
                end
                SHIFT_ASR:
                begin
                    cout = x[31];
                    return {32{x[31]}};
                end
                default:
                begin
                    cout = x[0];
                    return {cin, x[31:1]};
                end
            endcase
        end
        case (kind)
            SHIFT_LSL:
            begin
                if (n < 32) begin
                    cout = x[32 - n];
                    return x << n;
                end
                cout = (n == 32) ? x[0] : 1'b0;
                return '0;
            end
            SHIFT_LSR:
            begin
                if (n < 32) begin
                    cout = x[n - 1];
                    return x >> n;
                end
                cout = (n == 32) ? x[31] : 1'b0;
                return '0;
            end
            SHIFT_ASR:
            begin
                if (n < 32) begin
                    cout = x[n - 1];
                    return $signed(x) >>> n;
                end
                cout = x[31];
                return {32{x[31]}};
            end
            default:
            begin
                if (rot == 0) begin
                    cout = x[31];
                    return x;
                end
                cout = x[rot - 1];
                return (x >> rot) | (x << (32 - rot));
            end
        endcase
    endfunction

    // expected result of one instruction and the flags it leaves behind
    function automatic alu_result_t predict_alu(input logic [31:0] ins, rn_val, rm_val,
            rs_val, input logic [3:0] f, output logic [3:0] f_next);
        alu_result_t r;
        alu_op_t     opc;
        logic [3:0]  rd;
        logic        s_bit, cin, passed, is_test, unsup, sc, arith, we, carry_in;
        logic [31:0] op1, rm, op2, res, a, b, imm_word;
        logic [4:0]  rot;
        logic [32:0] sum;
        logic [3:0]  nf;

        opc = alu_op_t'(ins[24:21]);
        rd = ins[15:12];
        s_bit = ins[20];
        cin = f[FlagC];
        passed = cond_holds(ins[31:28], f);
        is_test = (ins[24:23] == 2'b10);
        // test opcodes without S are PSR transfers
        unsup = !s_bit && is_test;
        op1 = rn_val;
        rm = rm_val;
        op2 = '0;
        res = '0;
        a = '0;
        b = '0;
        carry_in = 1'b0;
        arith = 1'b0;
        we = 1'b0;
        sc = cin;
        f_next = f;

        if (passed && !unsup) begin
            // operand two
            if (ins[25]) begin
                imm_word = {24'd0, ins[7:0]};
                rot = {ins[11:8], 1'b0};
                if (rot == 0) begin
                    op2 = imm_word;
                end
                else begin
                    op2 = (imm_word >> rot) | (imm_word << (32 - rot));
                    sc = op2[31];
                end
            end
            else if (ins[4]) begin
                // pc reads one word further ahead with a register shift
                if (ins[19:16] == PcIndex)
                    op1 = op1 + 32'd4;
                if (ins[3:0] == PcIndex)
                    rm = rm + 32'd4;
                op2 = barrel_shift(rm, shift_kind_t'(ins[6:5]), rs_val[7:0], 1'b0, cin, sc);
            end
            else begin
                op2 = barrel_shift(rm, shift_kind_t'(ins[6:5]), {3'd0, ins[11:7]}, 1'b1,
                                   cin, sc);
            end

            // alu operation
            case (opc)
                OP_AND, OP_TST: res = op1 & op2;
                OP_EOR, OP_TEQ: res = op1 ^ op2;
                OP_SUB, OP_CMP:
                begin
                    a = op1;
                    b = ~op2;
                    carry_in = 1'b1;
                    arith = 1'b1;
                end
                OP_RSB:
                begin
                    a = op2;
                    b = ~op1;
                    carry_in = 1'b1;
                    arith = 1'b1;
                end
                OP_ADD, OP_CMN:
                begin
                    a = op1;
                    b = op2;
                    arith = 1'b1;
                end
                OP_ADC:
                begin
                    a = op1;
                    b = op2;
                    carry_in = cin;
                    arith = 1'b1;
                end
                OP_SBC:
                begin
                    a = op1;
                    b = ~op2;
                    carry_in = cin;
                    arith = 1'b1;
                end
                OP_RSC:
                begin
                    a = op2;
                    b = ~op1;
                    carry_in = cin;
                    arith = 1'b1;
                end
                OP_ORR: res = op1 | op2;
                OP_MOV: res = op2;
                OP_BIC: res = op1 & ~op2;
                default: res = ~op2;
            endcase

            nf = '0;
            if (arith) begin
                sum = {1'b0, a} + {1'b0, b} + {32'd0, carry_in};
                res = sum[31:0];
                sc = sum[32];
                nf[FlagV] = (a[31] ^ res[31]) & (b[31] ^ res[31]);
            end
            else begin
                nf[FlagV] = f[FlagV];
            end

            // flags written by test opcodes and by S unless the target is pc
            if (is_test || (s_bit && rd != PcIndex)) begin
                nf[FlagN] = res[31];
                nf[FlagZ] = (res == '0);
                nf[FlagC] = sc;
                f_next = nf;
            end
            we = !is_test;
        end

        r.result_value = we ? res : '0;
        r.dest_index = rd;
        r.write_enable = we;
        r.cond_passed = passed;
        r.flags_out = f_next;
        r.flush_pipe = we && (rd == PcIndex);
        r.unsupported = unsup;
        return r;
    endfunction

    // instruction word builders for the directed items
    function automatic logic [31:0] dp_imm(input cond_t cc, input alu_op_t op,
            input logic s, input logic [3:0] rn, rd, rot, input logic [7:0] imm8);
        return {cc, 3'b001, op, s, rn, rd, rot, imm8};
    endfunction

    function automatic logic [31:0] dp_shift_imm(input cond_t cc, input alu_op_t op,
            input logic s, input logic [3:0] rn, rd, input logic [4:0] amt,
            input shift_kind_t kind, input logic [3:0] rm);
        return {cc, 3'b000, op, s, rn, rd, amt, kind, 1'b0, rm};
    endfunction

    function automatic logic [31:0] dp_shift_reg(input cond_t cc, input alu_op_t op,
            input logic s, input logic [3:0] rn, rd, rs, input shift_kind_t kind,
            input logic [3:0] rm);
        return {cc, 3'b000, op, s, rn, rd, rs, 1'b0, kind, 1'b1, rm};
    endfunction

    // random operands, weighted toward the corner values
    function automatic logic [31:0] random_word();
        case ($urandom_range(7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return $urandom_range(255);
            default: return $urandom();
        endcase
    endfunction

    // rs value: often a small shift amount in the low byte
    function automatic logic [31:0] random_shift();
        logic [31:0] w;
        w = $urandom();
        if ($urandom_range(1) == 0)
            w[7:0] = 8'($urandom_range(40));
        return w;
    endfunction

    // random instruction, biased toward always-execute and S set
    function automatic logic [31:0] random_instr();
        logic [31:0] ins;
        ins = $urandom();
        if ($urandom_range(99) < 40)
            ins[31:28] = COND_AL;
        if ($urandom_range(99) < 50)
            ins[20] = 1'b1;
        return ins;
    endfunction

    // offer one instruction, wait for its transfer and record the prediction
    task automatic send_instr(input logic [31:0] ins, rn_val, rm_val, rs_val);
        alu_result_t want;
        logic [3:0]  next_flags;
        logic        offered;
        offered = 1'b0;
        while (!offered) begin
            @(negedge clk);
            if ($urandom_range(99) < send_idle_pct) begin
                s_tvalid <= 1'b0;
            end
            else begin
                s_tdata <= {rs_val, rm_val, rn_val, ins};
                s_tvalid <= 1'b1;
                offered = 1'b1;
            end
        end
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        want = predict_alu(ins, rn_val, rm_val, rs_val, model_flags, next_flags);
        model_flags = next_flags;
        expected_results.push_back(want);
        items_sent++;
    endtask

    // receiver ready, with a long hold-off on request
    always @(negedge clk) begin
        if (long_stall_req) begin
            long_stall_req = 1'b0;
            stall_left = LongStallCycles;
        end
        if (stall_left != 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic check_field(input string what, input logic [31:0] want, got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= MaxReported)
                $display("mismatch in result %0d, %s: expected %h, got %h",
                         results_checked, what, want, got);
        end
    endtask

    // compare each result transfer with the oldest expectation
    always @(posedge clk) begin : result_check
        alu_result_t want;
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MaxReported)
                    $display("unexpected result transfer: %h", m_tdata);
            end
            else begin
                want = expected_results.pop_front();
                check_field("result_value", want.result_value, m_tdata[31:0]);
                check_field("dest_index", {28'd0, want.dest_index}, {28'd0, m_tdata[35:32]});
                check_field("write_enable", {31'd0, want.write_enable}, {31'd0, m_tdata[36]});
                check_field("cond_passed", {31'd0, want.cond_passed}, {31'd0, m_tdata[37]});
                check_field("flags_out", {28'd0, want.flags_out}, {28'd0, m_tdata[41:38]});
                check_field("flush_pipe", {31'd0, want.flush_pipe}, {31'd0, m_tdata[42]});
                check_field("unsupported", {31'd0, want.unsupported}, {31'd0, m_tdata[43]});
            end
            results_checked++;
        end
    end

    // run limit
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("cond_data_processing_alu_tb failed");
            $finish;
        end
    end

    // corner cases of conditions, shifter, opcodes and pc handling
    task automatic test_directed();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        // all-zero word fails EQ with clear flags, all-ones word never executes
        send_instr(32'h0000_0000, 32'h0, 32'h0, 32'h0);
        send_instr(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // moves: zero result, then rotated immediate sets carry from bit 31
        send_instr(dp_imm(COND_AL, OP_MOV, 1'b1, 4'd0, 4'd0, 4'd0, 8'h00), 32'h1, 32'h2, 32'h3);
        send_instr(dp_imm(COND_AL, OP_MOV, 1'b1, 4'd0, 4'd1, 4'd1, 8'hFF), 32'h0, 32'h0, 32'h0);
        // condition fails, nothing changes
        send_instr(dp_shift_imm(COND_EQ, OP_ADD, 1'b1, 4'd1, 4'd2, 5'd0, SHIFT_LSL, 4'd3),
                   32'h5, 32'h6, 32'h0);
        // arithmetic carries and overflows
        send_instr(dp_shift_imm(COND_AL, OP_ADD, 1'b1, 4'd2, 4'd3, 5'd0, SHIFT_LSL, 4'd4),
                   32'hFFFF_FFFF, 32'h1, 32'h0);
        send_instr(dp_shift_imm(COND_AL, OP_ADC, 1'b1, 4'd2, 4'd3, 5'd0, SHIFT_LSL, 4'd4),
                   32'h7FFF_FFFF, 32'h0, 32'h0);
        send_instr(dp_shift_imm(COND_AL, OP_SUB, 1'b1, 4'd2, 4'd3, 5'd0, SHIFT_LSL, 4'd4),
                   32'h0, 32'h1, 32'h0);
        send_instr(dp_shift_imm(COND_AL, OP_SBC, 1'b1, 4'd2, 4'd3, 5'd0, SHIFT_LSL, 4'd4),
                   32'h8000_0000, 32'h0, 32'h0);
        send_instr(dp_shift_imm(COND_AL, OP_RSB, 1'b1, 4'd2, 4'd3, 5'd0, SHIFT_LSL, 4'd4),
                   32'h1, 32'h0, 32'h0);
        send_instr(dp_shift_imm(COND_AL, OP_RSC, 1'b1, 4'd2, 4'd3, 5'd0, SHIFT_LSL, 4'd4),
                   32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
        // test opcodes update flags only, without S they are PSR transfers
        send_instr(dp_shift_imm(COND_AL, OP_CMP, 1'b1, 4'd5, 4'd6, 5'd0, SHIFT_LSL, 4'd7),
                   32'h5, 32'h5, 32'h0);
        send_instr(dp_shift_imm(COND_AL, OP_CMN, 1'b1, 4'd5, 4'd6, 5'd0, SHIFT_LSL, 4'd7),
                   32'h8000_0000, 32'h8000_0000, 32'h0);
        send_instr(dp_imm(COND_AL, OP_TST, 1'b1, 4'd5, 4'd6, 4'd4, 8'h80), 32'hFFFF_FFFF,
                   32'h0, 32'h0);
        send_instr(dp_shift_imm(COND_AL, OP_TEQ, 1'b1, 4'd5, 4'd6, 5'd1, SHIFT_LSL, 4'd7),
                   32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0);
        send_instr(dp_imm(COND_AL, OP_TST, 1'b0, 4'd5, 4'd6, 4'd0, 8'h01), 32'h1, 32'h0, 32'h0);
        send_instr(dp_shift_imm(COND_AL, OP_CMN, 1'b0, 4'd5, 4'd6, 5'd0, SHIFT_LSL, 4'd7),
                   32'h1, 32'h1, 32'h0);
        // immediate shifts of zero: LSR #32, ASR #32, RRX
        send_instr(dp_shift_imm(COND_AL, OP_AND, 1'b1, 4'd1, 4'd2, 5'd0, SHIFT_LSR, 4'd3),
                   32'hFFFF_FFFF, 32'h8000_0000, 32'h0);
        send_instr(dp_shift_imm(COND_AL, OP_EOR, 1'b1, 4'd1, 4'd2, 5'd0, SHIFT_ASR, 4'd3),
                   32'h0, 32'h8000_0000, 32'h0);
        send_instr(dp_shift_imm(COND_AL, OP_ORR, 1'b1, 4'd1, 4'd2, 5'd0, SHIFT_ROR, 4'd3),
                   32'h0, 32'h0000_0003, 32'h0);
        // register shifts: by 32, by zero low byte with high bits set, beyond 32
        send_instr(dp_shift_reg(COND_AL, OP_BIC, 1'b1, 4'd1, 4'd2, 4'd4, SHIFT_LSL, 4'd3),
                   32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0020);
        send_instr(dp_shift_reg(COND_AL, OP_MVN, 1'b1, 4'd1, 4'd2, 4'd4, SHIFT_LSR, 4'd3),
                   32'h0, 32'h8000_0001, 32'h1234_5600);
        send_instr(dp_shift_reg(COND_AL, OP_MOV, 1'b1, 4'd1, 4'd2, 4'd4, SHIFT_ASR, 4'd3),
                   32'h0, 32'h8000_0000, 32'h0000_00C8);
        // register shift reading pc as Rn and Rm, rotate by 32
        send_instr(dp_shift_reg(COND_AL, OP_ADD, 1'b1, PcIndex, 4'd2, 4'd4, SHIFT_ROR, PcIndex),
                   32'h0000_1000, 32'h8000_2000, 32'h0000_0020);
        // pc as destination: with S flags stay, both flush
        send_instr(dp_imm(COND_AL, OP_MOV, 1'b1, 4'd0, PcIndex, 4'd0, 8'h04), 32'h0, 32'h0, 32'h0);
        send_instr(dp_shift_imm(COND_AL, OP_ADD, 1'b0, 4'd1, PcIndex, 5'd2, SHIFT_LSL, 4'd3),
                   32'h0000_0100, 32'h0000_0004, 32'h0);
    endtask

    // random instructions with one idle setting
    task automatic test_random_phase(input int unsigned idle_pct, stall_pct, count);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
            send_instr(random_instr(), random_word(), random_word(), random_shift());
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        long_stall_req = 1'b1;
        repeat (PressureItems)
            send_instr(random_instr(), random_word(), random_word(), random_shift());
    endtask

    initial begin
        repeat (ResetCycles) @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_phase(0, 0, PhaseItems);
        test_random_phase(57, 0, PhaseItems);
        test_random_phase(0, 57, PhaseItems);
        test_backpressure();
        test_random_phase(33, 33, PhaseItems);

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        $display("sent %0d instructions (directed corners, four idle mixes, long hold-off)",
                 items_sent);
        $display("checked %0d results, %0d mismatches", results_checked, mismatch_count);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("cond_data_processing_alu_tb passed");
        else
            $display("cond_data_processing_alu_tb failed");
        $finish;
    end

endmodule

### files.f
design/cdp_alu_pkg.sv
design/cond_data_processing_alu.sv
tb/sv/cond_data_processing_alu_tb.sv
